// File: rtl/core/leader_election_node_defines.svh
// Assertion macros shared by the leader election node RTL
`ifndef LEADER_ELECTION_NODE_DEFINES_SVH
`define LEADER_ELECTION_NODE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define LENODE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LENODE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/lenode_pkg.sv
// Shared widths, types and codes of the leader election node
`timescale 1ns / 1ps

package lenode_pkg;

  localparam int HALF_W    = 64;
  localparam int ADDR_W    = 2 * HALF_W;
  localparam int DIGIT_W   = 8;
  localparam int MEAN_W    = 16;
  localparam int KIND_W    = 3;
  localparam int ACTION_W  = 2;
  localparam int ROLE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int HEARD_W   = 8;

  localparam int MAX_CLIENTS_DEF = 16;
  localparam int MEAN_WEIGHT_DEF = 16;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [ACTION_W-1:0]  action_t;
  typedef logic [ROLE_W-1:0]    role_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [HEARD_W-1:0]   heard_t;

  localparam kind_t KIND_INTERVAL = 3'd0;
  localparam kind_t KIND_BCAST    = 3'd1;
  localparam kind_t KIND_ALIVE    = 3'd2;
  localparam kind_t KIND_TIMEOUT  = 3'd3;
  localparam kind_t KIND_JOIN     = 3'd4;
  localparam kind_t KIND_SENSOR   = 3'd5;
  localparam kind_t KIND_THRESH   = 3'd6;

  localparam action_t ACT_BCAST   = 2'd0;
  localparam action_t ACT_QUERY   = 2'd1;
  localparam action_t ACT_REG     = 2'd2;
  localparam action_t ACT_PUBLISH = 2'd3;

  localparam role_t ROLE_DISCOVER = 2'd0;
  localparam role_t ROLE_CLIENT   = 2'd1;
  localparam role_t ROLE_COORD    = 2'd2;

  localparam cfg_idx_t CFG_OWN_HIGH = 2'd0;
  localparam cfg_idx_t CFG_OWN_LOW  = 2'd1;

  localparam heard_t HEARD_MAX = '1;
  localparam heard_t HEARD_ONE = 8'd1;

endpackage

// File: rtl/core/lenode_in_if.sv
// Event channel of the leader election node
`timescale 1ns / 1ps

interface lenode_in_if;
  import lenode_pkg::*;

  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic [HALF_W-1:0]        addr_high;
  logic [HALF_W-1:0]        addr_low;
  logic signed [MEAN_W-1:0] sensor_value;

  modport source (output valid, kind, addr_high, addr_low, sensor_value, input ready);
  modport sink   (input valid, kind, addr_high, addr_low, sensor_value, output ready);
endinterface

// File: rtl/core/lenode_out_if.sv
// Action channel of the leader election node
`timescale 1ns / 1ps

interface lenode_out_if;
  import lenode_pkg::*;

  logic                     valid;
  logic                     ready;
  action_t                  action;
  logic [HALF_W-1:0]        target_high;
  logic [HALF_W-1:0]        target_low;
  logic signed [MEAN_W-1:0] mean_value;
  role_t                    role;
  logic                     last;

  modport source (output valid, action, target_high, target_low, mean_value, role, last,
                  input ready);
  modport sink   (input valid, action, target_high, target_low, mean_value, role, last,
                  output ready);
endinterface

// File: rtl/core/lenode_cfg_if.sv
// Configuration write channel of the leader election node
`timescale 1ns / 1ps

interface lenode_cfg_if;
  import lenode_pkg::*;

  logic              valid;
  logic              ready;
  cfg_idx_t          index;
  logic [HALF_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/lenode_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps

module lenode_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/leader_election_node.sv
// Leader election controller of one network node
//
// Channels: evt takes one event (kind, address, sensor value); act gives the
// actions it causes, with last set on the final one; cfg writes the node's own
// address (index 0 upper half, index 1 lower half) and is always ready.
// One event is worked at a time; evt.ready is high while the node is idle.
// States worked per event:
//   alive, join, threshold to coordinator, unknown kind: idle state only
//   broadcast: the addresses compared one byte per cycle in the compare state
//   broadcast action or register action: the emit state
//   interval as coordinator: read and emit per client, one table read each
//   sensor as coordinator: magnitude state, ACC_W-bit restoring divider
//   giving one quotient bit per cycle (ACC_W = 21 at a weight of 16)
// Results sit in an output register; when act stalls, the sequencer holds at
// the next result until the register is free.
// Reset puts the node in discover with broadcasting on, the mean at -1 and
// the client table empty; table entries are written before they are read.
`timescale 1ns / 1ps
`include "leader_election_node_defines.svh"

module leader_election_node #(
  parameter int MAX_CLIENTS = lenode_pkg::MAX_CLIENTS_DEF,
  parameter int MEAN_WEIGHT = lenode_pkg::MEAN_WEIGHT_DEF
) (
  input logic          clk,
  input logic          rst,
  lenode_in_if.sink    evt,
  lenode_out_if.source act,
  lenode_cfg_if.sink   cfg
);
  import lenode_pkg::*;

  localparam int IDX_W     = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CNT_W     = $clog2(MAX_CLIENTS + 1);
  localparam int W_W       = $clog2(MEAN_WEIGHT + 1);
  localparam int ACC_W     = MEAN_W + $clog2(MEAN_WEIGHT) + 1;
  localparam int CMP_STEPS = ADDR_W / DIGIT_W;
  localparam int STEP_W    = ($clog2(ACC_W) > $clog2(CMP_STEPS)) ?
                             $clog2(ACC_W) : $clog2(CMP_STEPS);

  localparam logic [STEP_W-1:0]    CMP_LAST = STEP_W'(CMP_STEPS - 1);
  localparam logic [STEP_W-1:0]    DIV_LAST = STEP_W'(ACC_W - 1);
  localparam logic [CNT_W-1:0]     CNT_MAX  = CNT_W'(MAX_CLIENTS);
  localparam logic [CNT_W-1:0]     CNT_ONE  = CNT_W'(1);
  localparam logic signed [ACC_W-1:0] WM1   = ACC_W'(MEAN_WEIGHT - 1);
  localparam logic [W_W:0]         DIVISOR  = (W_W + 1)'(MEAN_WEIGHT);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CMP   = 4'd1;
  localparam logic [3:0] S_ABS   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_EMIT  = 4'd4;
  localparam logic [3:0] S_QRD   = 4'd5;
  localparam logic [3:0] S_QEMIT = 4'd6;

  logic [3:0]               state;
  logic [ADDR_W-1:0]        own_addr;
  logic [ADDR_W-1:0]        last_heard;
  logic [ADDR_W-1:0]        coord_addr;
  role_t                    role_reg;
  logic                     broadcasting;
  logic                     heard_activity;
  heard_t                   heard_count;
  logic [CNT_W-1:0]         client_count;
  logic signed [MEAN_W-1:0] running_mean;

  logic [STEP_W-1:0]        step;
  logic                     cmp_lt;
  logic                     cmp_gt;
  logic                     cmp_ne;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_neg;
  logic [ACC_W-1:0]         dq;
  logic [W_W-1:0]           rem;
  logic [IDX_W-1:0]         qidx;
  action_t                  em_action;

  logic                     out_valid;
  action_t                  out_action;
  logic [ADDR_W-1:0]        out_target;
  logic signed [MEAN_W-1:0] out_mean;
  role_t                    out_role;
  logic                     out_last;

  logic                     accept;
  logic                     out_free;
  logic                     out_load;
  logic                     tbl_we;
  logic [IDX_W-1:0]         tbl_waddr;
  logic [ADDR_W-1:0]        tbl_wdata;
  logic                     tbl_re;
  logic [ADDR_W-1:0]        tbl_rdata;
  logic                     join_ok;
  logic                     found_coord;

  logic [DIGIT_W-1:0]       own_dig;
  logic [DIGIT_W-1:0]       heard_dig;
  logic [DIGIT_W-1:0]       coord_dig;
  logic                     lt_fin;
  logic                     ne_fin;
  logic                     fall_back;

  logic [W_W:0]             rem_sh;
  logic                     div_ge;
  logic [W_W:0]             rem_sub;
  logic [ACC_W-1:0]         quot_fin;
  logic [MEAN_W-1:0]        quot_cut;
  logic                     q_last;

  assign accept    = evt.valid && evt.ready;
  assign evt.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free  = !out_valid || act.ready;
  assign out_load  = out_free && ((state == S_EMIT) || (state == S_QEMIT));

  assign act.valid       = out_valid;
  assign act.action      = out_action;
  assign act.target_high = out_target[ADDR_W-1:HALF_W];
  assign act.target_low  = out_target[HALF_W-1:0];
  assign act.mean_value  = out_mean;
  assign act.role        = out_role;
  assign act.last        = out_last;

  assign join_ok     = (role_reg == ROLE_COORD) && (client_count < CNT_MAX);
  assign found_coord = (role_reg == ROLE_DISCOVER) && (heard_count == HEARD_ONE) &&
                       broadcasting;

  assign tbl_we    = accept && (((evt.kind == KIND_JOIN) && join_ok) ||
                                ((evt.kind == KIND_THRESH) && found_coord));
  assign tbl_waddr = (evt.kind == KIND_THRESH) ? '0 : client_count[IDX_W-1:0];
  assign tbl_wdata = (evt.kind == KIND_THRESH) ? own_addr :
                     {evt.addr_high, evt.addr_low};
  assign tbl_re    = (state == S_QRD);

  assign own_dig   = own_addr[ADDR_W-1 -: DIGIT_W];
  assign heard_dig = last_heard[ADDR_W-1 -: DIGIT_W];
  assign coord_dig = coord_addr[ADDR_W-1 -: DIGIT_W];
  assign lt_fin    = cmp_lt || (!cmp_lt && !cmp_gt && (own_dig < heard_dig));
  assign ne_fin    = cmp_ne || (coord_dig != heard_dig);
  assign fall_back = (role_reg != ROLE_DISCOVER) && ne_fin;

  assign rem_sh   = {rem, dq[ACC_W-1]};
  assign div_ge   = (rem_sh >= DIVISOR);
  assign rem_sub  = rem_sh - DIVISOR;
  assign quot_fin = {dq[ACC_W-2:0], div_ge};
  assign quot_cut = quot_fin[MEAN_W-1:0];

  assign q_last = ((CNT_W'(qidx) + CNT_ONE) == client_count);

  lenode_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_CLIENTS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (qidx),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      own_addr       <= '0;
      last_heard     <= '0;
      coord_addr     <= '0;
      role_reg       <= ROLE_DISCOVER;
      broadcasting   <= 1'b1;
      heard_activity <= 1'b0;
      heard_count    <= '0;
      client_count   <= '0;
      running_mean   <= '1;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_OWN_HIGH: own_addr[ADDR_W-1:HALF_W] <= cfg.data;
          CFG_OWN_LOW:  own_addr[HALF_W-1:0]      <= cfg.data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (act.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (evt.kind)
              KIND_INTERVAL: begin
                if (role_reg == ROLE_DISCOVER && broadcasting) begin
                  em_action <= ACT_BCAST;
                  state     <= S_EMIT;
                end else if (role_reg == ROLE_COORD && client_count != '0) begin
                  qidx  <= '0;
                  state <= S_QRD;
                end
              end
              KIND_BCAST: begin
                heard_activity <= 1'b1;
                last_heard     <= {evt.addr_high, evt.addr_low};
                step           <= '0;
                cmp_lt         <= 1'b0;
                cmp_gt         <= 1'b0;
                cmp_ne         <= 1'b0;
                state          <= S_CMP;
              end
              KIND_ALIVE: begin
                heard_activity <= 1'b1;
              end
              KIND_TIMEOUT: begin
                if (role_reg != ROLE_COORD && !heard_activity) begin
                  coord_addr   <= '0;
                  role_reg     <= ROLE_DISCOVER;
                  broadcasting <= 1'b1;
                  em_action    <= ACT_BCAST;
                  state        <= S_EMIT;
                end
                heard_activity <= 1'b0;
              end
              KIND_JOIN: begin
                if (join_ok) begin
                  client_count <= client_count + CNT_ONE;
                end
              end
              KIND_SENSOR: begin
                if (role_reg == ROLE_COORD) begin
                  acc   <= ACC_W'(running_mean) * WM1 + ACC_W'(evt.sensor_value);
                  state <= S_ABS;
                end
              end
              KIND_THRESH: begin
                if (role_reg == ROLE_DISCOVER) begin
                  if (heard_count == HEARD_ONE) begin
                    if (broadcasting) begin
                      role_reg     <= ROLE_COORD;
                      coord_addr   <= own_addr;
                      client_count <= CNT_ONE;
                      running_mean <= evt.sensor_value;
                    end else begin
                      role_reg   <= ROLE_CLIENT;
                      coord_addr <= last_heard;
                      em_action  <= ACT_REG;
                      state      <= S_EMIT;
                    end
                  end
                  heard_count <= '0;
                end
              end
              default: ;
            endcase
          end
        end

        S_CMP: begin
          own_addr   <= {own_addr[ADDR_W-DIGIT_W-1:0], own_dig};
          last_heard <= {last_heard[ADDR_W-DIGIT_W-1:0], heard_dig};
          coord_addr <= (step == CMP_LAST && fall_back) ? '0 :
                        {coord_addr[ADDR_W-DIGIT_W-1:0], coord_dig};
          if (!cmp_lt && !cmp_gt) begin
            cmp_lt <= (own_dig < heard_dig);
            cmp_gt <= (own_dig > heard_dig);
          end
          cmp_ne <= ne_fin;
          step   <= step + STEP_W'(1);
          if (step == CMP_LAST) begin
            if (fall_back) begin
              role_reg <= ROLE_DISCOVER;
            end
            if (fall_back || role_reg == ROLE_DISCOVER) begin
              if (heard_count != HEARD_MAX) begin
                heard_count <= heard_count + HEARD_ONE;
              end
              broadcasting <= !lt_fin && (fall_back || broadcasting);
            end
            state <= S_IDLE;
          end
        end

        S_ABS: begin
          acc_neg <= acc[ACC_W-1];
          dq      <= acc[ACC_W-1] ? $unsigned(-acc) : $unsigned(acc);
          rem     <= '0;
          step    <= '0;
          state   <= S_DIV;
        end

        S_DIV: begin
          rem  <= div_ge ? rem_sub[W_W-1:0] : rem_sh[W_W-1:0];
          dq   <= quot_fin;
          step <= step + STEP_W'(1);
          if (step == DIV_LAST) begin
            running_mean <= acc_neg ? $signed(~quot_cut + MEAN_W'(1)) : $signed(quot_cut);
            em_action    <= ACT_PUBLISH;
            state        <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_action <= em_action;
            out_role   <= role_reg;
            out_last   <= 1'b1;
            out_mean   <= (em_action == ACT_PUBLISH) ? running_mean : '0;
            priority case (em_action)
              ACT_BCAST: out_target <= own_addr;
              ACT_REG:   out_target <= coord_addr;
              default:   out_target <= '0;
            endcase
            state <= S_IDLE;
          end
        end

        S_QRD: begin
          state <= S_QEMIT;
        end

        S_QEMIT: begin
          if (out_free) begin
            out_action <= ACT_QUERY;
            out_role   <= role_reg;
            out_last   <= q_last;
            out_mean   <= '0;
            out_target <= tbl_rdata;
            if (q_last) begin
              state <= S_IDLE;
            end else begin
              qidx  <= qidx + IDX_W'(1);
              state <= S_QRD;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `LENODE_ASSERT_IMP(a_count_bound, 1'b1, client_count <= CNT_MAX, "client count beyond table size")
  `LENODE_ASSERT_IMP(a_coord_has_client, role_reg == ROLE_COORD, client_count != '0, "coordinator with empty table")
  `LENODE_ASSERT_NXT(a_bcast_compares, accept && evt.kind == KIND_BCAST, state == S_CMP, "broadcast event did not start compare")
  `LENODE_ASSERT_IMP(a_query_as_coord, act.valid && act.action == ACT_QUERY, act.role == ROLE_COORD, "query issued outside coordinator role")

endmodule

// File: dv/tb.sv
// Self-checking testbench for the leader election node with a built-in action predictor
`timescale 1ns / 1ps

module tb;
  import lenode_pkg::*;

  localparam int    LONG_HOLD     = 300;
  localparam int    SETTLE_CYCLES = 60;
  localparam int    DIRECTED_N    = 25;
  localparam int    PHASE_N       = 90;
  localparam int    N_PHASES      = 4;
  localparam kind_t KIND_UNUSED   = 3'd7;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct {
    action_t                  action;
    logic [HALF_W-1:0]        target_high;
    logic [HALF_W-1:0]        target_low;
    logic signed [MEAN_W-1:0] mean_value;
    role_t                    role;
    logic                     last;
  } action_rec_t;

  class action_tracker;
    logic [HALF_W-1:0] own_hi, own_lo;
    role_t             role;
    bit                bcasting, activity;
    heard_t            heard;
    logic [HALF_W-1:0] last_hi, last_lo, coord_hi, coord_lo;
    logic [HALF_W-1:0] tab_hi [MAX_CLIENTS_DEF];
    logic [HALF_W-1:0] tab_lo [MAX_CLIENTS_DEF];
    int                clients;
    int                mean;
    action_rec_t       pending_actions[$];
    int                errors, n_checked, n_dropped, most_per_event;

    function new();
      own_hi = '0;
      own_lo = '0;
      role = ROLE_DISCOVER;
      bcasting = 1'b1;
      activity = 1'b0;
      heard = '0;
      last_hi = '0;
      last_lo = '0;
      coord_hi = '0;
      coord_lo = '0;
      clients = 0;
      mean = -1;
      errors = 0;
      n_checked = 0;
      n_dropped = 0;
      most_per_event = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [HALF_W-1:0] data);
      case (idx)
        CFG_OWN_HIGH: own_hi = data;
        CFG_OWN_LOW:  own_lo = data;
        default: ;
      endcase
    endfunction

    function void add(action_t a, logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo,
                      logic signed [MEAN_W-1:0] m);
      action_rec_t r;
      r.action = a;
      r.target_high = hi;
      r.target_low = lo;
      r.mean_value = m;
      r.role = role;
      r.last = 1'b0;
      pending_actions.push_back(r);
    endfunction

    function void fall_back();
      coord_hi = '0;
      coord_lo = '0;
      role = ROLE_DISCOVER;
      bcasting = 1'b1;
    endfunction

    function void note_event(kind_t kind, logic [HALF_W-1:0] ahi, logic [HALF_W-1:0] alo,
                             logic signed [MEAN_W-1:0] sval);
      int          first;
      int          acc;
      action_rec_t r;
      first = pending_actions.size();
      case (kind)
        KIND_INTERVAL: begin
          if (role == ROLE_DISCOVER) begin
            if (bcasting) add(ACT_BCAST, own_hi, own_lo, '0);
          end else if (role == ROLE_COORD) begin
            for (int i = 0; i < clients; i++) add(ACT_QUERY, tab_hi[i], tab_lo[i], '0);
          end
        end
        KIND_BCAST: begin
          activity = 1'b1;
          last_hi = ahi;
          last_lo = alo;
          if (role != ROLE_DISCOVER && {coord_hi, coord_lo} != {ahi, alo}) fall_back();
          if (role == ROLE_DISCOVER) begin
            if (heard != HEARD_MAX) heard = heard + 1'b1;
            if ({own_hi, own_lo} < {ahi, alo}) bcasting = 1'b0;
          end
        end
        KIND_ALIVE: activity = 1'b1;
        KIND_TIMEOUT: begin
          if (role != ROLE_COORD && !activity) begin
            fall_back();
            add(ACT_BCAST, own_hi, own_lo, '0);
          end
          activity = 1'b0;
        end
        KIND_JOIN: begin
          if (role == ROLE_COORD) begin
            if (clients < MAX_CLIENTS_DEF) begin
              tab_hi[clients] = ahi;
              tab_lo[clients] = alo;
              clients++;
            end else begin
              n_dropped++;
            end
          end
        end
        KIND_SENSOR: begin
          if (role == ROLE_COORD) begin
            acc = (MEAN_WEIGHT_DEF - 1) * mean + int'(sval);
            mean = acc / MEAN_WEIGHT_DEF;
            add(ACT_PUBLISH, '0, '0, MEAN_W'(mean));
          end
        end
        KIND_THRESH: begin
          if (role == ROLE_DISCOVER) begin
            if (heard == HEARD_ONE) begin
              if (bcasting) begin
                role = ROLE_COORD;
                coord_hi = own_hi;
                coord_lo = own_lo;
                tab_hi[0] = own_hi;
                tab_lo[0] = own_lo;
                clients = 1;
                mean = int'(sval);
              end else begin
                role = ROLE_CLIENT;
                coord_hi = last_hi;
                coord_lo = last_lo;
                add(ACT_REG, coord_hi, coord_lo, '0);
              end
            end
            heard = '0;
          end
        end
        default: ;
      endcase
      if (pending_actions.size() - first > most_per_event)
        most_per_event = pending_actions.size() - first;
      if (pending_actions.size() > first) begin
        r = pending_actions.pop_back();
        r.last = 1'b1;
        pending_actions.push_back(r);
      end
    endfunction

    function void report(string field, logic [HALF_W-1:0] want, logic [HALF_W-1:0] got);
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_action(action_rec_t got);
      action_rec_t want;
      if (pending_actions.size() == 0) begin
        $display("%0t: unexpected action %0d target %h_%h, expected none",
                 $time, got.action, got.target_high, got.target_low);
        errors++;
        return;
      end
      want = pending_actions.pop_front();
      n_checked++;
      if (got.action !== want.action)
        report("action", 64'(want.action), 64'(got.action));
      if (got.target_high !== want.target_high)
        report("target_high", want.target_high, got.target_high);
      if (got.target_low !== want.target_low)
        report("target_low", want.target_low, got.target_low);
      if (got.mean_value !== want.mean_value)
        report("mean_value", 64'(want.mean_value), 64'(got.mean_value));
      if (got.role !== want.role) report("role", 64'(want.role), 64'(got.role));
      if (got.last !== want.last) report("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  lenode_in_if  evt ();
  lenode_out_if act ();
  lenode_cfg_if cfg ();

  leader_election_node u_dut (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .act (act),
    .cfg (cfg)
  );

  action_tracker tracker = new();

  int          n_events = 0;
  int          n_settings = 0;
  int          burst_left = 0;
  logic        hold_req;
  logic        hold_seen;
  int          hold_left = 0;
  logic [15:0] rx_cyc = '0;
  action_rec_t got;

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      act.ready <= 1'b0;
      hold_seen <= 1'b0;
      hold_left = 0;
    end else begin
      if (act.valid && act.ready) begin
        got.action = act.action;
        got.target_high = act.target_high;
        got.target_low = act.target_low;
        got.mean_value = act.mean_value;
        got.role = act.role;
        got.last = act.last;
        tracker.check_action(got);
      end
      rx_cyc = rx_cyc + 1'b1;
      if (hold_left != 0) begin
        hold_left--;
        act.ready <= 1'b0;
      end else if (hold_req && !hold_seen) begin
        hold_left = LONG_HOLD;
        hold_seen <= 1'b1;
        act.ready <= 1'b0;
      end else begin
        case (rx_cyc[8:7])
          2'd1:    act.ready <= 1'($urandom_range(0, 1));
          2'd2:    act.ready <= (rx_cyc[1:0] == 2'b00);
          default: act.ready <= 1'b1;
        endcase
      end
    end
  end

  function automatic logic [HALF_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [MEAN_W-1:0] rand_sval();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return MEAN_W'($urandom);
    endcase
  endfunction

  // rel 0: not above own, 1: above own where possible, otherwise anything
  function automatic addr_t pick_addr(int rel);
    addr_t own, r;
    int    b;
    own = {tracker.own_hi, tracker.own_lo};
    r = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 3))
      0: begin
        b = $urandom_range(0, 15);
        r = own;
        r[8*b +: 8] = 8'($urandom);
      end
      1: r = own;
      default: ;
    endcase
    if (rel == 0 && r > own) r = r % (own + 1'b1);
    if (rel == 1 && r <= own) r = (own == '1) ? own : own + 1'b1 + (r % (~own));
    return r;
  endfunction

  task automatic send_event(input kind_t kind, input logic [HALF_W-1:0] ahi,
                            input logic [HALF_W-1:0] alo,
                            input logic signed [MEAN_W-1:0] sval);
    int gap;
    evt.valid <= 1'b1;
    evt.kind <= kind;
    evt.addr_high <= ahi;
    evt.addr_low <= alo;
    evt.sensor_value <= sval;
    do @(posedge clk); while (!evt.ready);
    tracker.note_event(kind, ahi, alo, sval);
    n_events++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        evt.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_at(input kind_t kind, input addr_t a);
    send_event(kind, a[ADDR_W-1:HALF_W], a[HALF_W-1:0], rand_sval());
  endtask

  task automatic settle();
    evt.valid <= 1'b0;
    while (tracker.pending_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_own_addr(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo);
    cfg.valid <= 1'b1;
    cfg.index <= CFG_OWN_HIGH;
    cfg.data <= hi;
    do @(posedge clk); while (!cfg.ready);
    tracker.set_reg(CFG_OWN_HIGH, hi);
    cfg.index <= CFG_OWN_LOW;
    cfg.data <= lo;
    do @(posedge clk); while (!cfg.ready);
    tracker.set_reg(CFG_OWN_LOW, lo);
    cfg.valid <= 1'b0;
    n_settings++;
    @(posedge clk);
  endtask

  // leave any role, clear the heard count and restore broadcasting
  task automatic enter_discover();
    addr_t a;
    if (tracker.role != ROLE_DISCOVER) begin
      a = pick_addr(2);
      if (a == {tracker.coord_hi, tracker.coord_lo}) a[0] = ~a[0];
      send_at(KIND_BCAST, a);
    end
    if (tracker.heard == HEARD_ONE) send_at(KIND_BCAST, pick_addr(2));
    send_at(KIND_THRESH, pick_addr(2));
    send_at(KIND_TIMEOUT, pick_addr(2));
    send_at(KIND_TIMEOUT, pick_addr(2));
  endtask

  task automatic coord_round();
    int joins, others;
    enter_discover();
    send_at(KIND_BCAST, pick_addr(0));
    send_at(KIND_THRESH, pick_addr(2));
    joins = ($urandom_range(0, 3) == 0) ? MAX_CLIENTS_DEF + 2 : $urandom_range(0, 5);
    others = $urandom_range(3, 10);
    while (joins + others > 0) begin
      if (joins > 0 && (others == 0 || $urandom_range(0, 1) == 0)) begin
        send_at(KIND_JOIN, pick_addr(2));
        joins--;
      end else begin
        others--;
        case ($urandom_range(0, 9))
          0, 1, 2: send_at(KIND_INTERVAL, pick_addr(2));
          3, 4, 5: send_at(KIND_SENSOR, pick_addr(2));
          6:       send_at(KIND_ALIVE, pick_addr(2));
          7:       send_at(KIND_TIMEOUT, pick_addr(2));
          8:       send_at(KIND_BCAST, {tracker.coord_hi, tracker.coord_lo});
          default: send_at(KIND_UNUSED, pick_addr(2));
        endcase
      end
    end
  endtask

  task automatic client_round();
    enter_discover();
    send_at(KIND_BCAST, pick_addr(1));
    send_at(KIND_THRESH, pick_addr(2));
    repeat ($urandom_range(3, 8)) begin
      case ($urandom_range(0, 9))
        0, 1:    send_at(KIND_ALIVE, pick_addr(2));
        2, 3:    send_at(KIND_TIMEOUT, pick_addr(2));
        4:       send_at(KIND_BCAST, {tracker.coord_hi, tracker.coord_lo});
        5:       send_at(KIND_BCAST, pick_addr(2));
        6:       send_at(KIND_INTERVAL, pick_addr(2));
        7:       send_at(KIND_SENSOR, pick_addr(2));
        8:       send_at(KIND_JOIN, pick_addr(2));
        default: send_at(KIND_THRESH, pick_addr(2));
      endcase
    end
  endtask

  task automatic noise_round();
    repeat ($urandom_range(3, 8)) send_at(kind_t'($urandom_range(0, 7)), pick_addr(2));
  endtask

  initial begin
    int pick;
    rst <= 1'b1;
    evt.valid <= 1'b0;
    evt.kind <= KIND_INTERVAL;
    evt.addr_high <= '0;
    evt.addr_low <= '0;
    evt.sensor_value <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_OWN_HIGH;
    cfg.data <= '0;
    hold_req <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_own_addr(64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef);
    send_event(KIND_INTERVAL, '0, '0, '0);
    send_event(KIND_UNUSED, '1, '1, 16'shffff);
    send_event(KIND_ALIVE, '0, '0, '0);
    send_event(KIND_TIMEOUT, '0, '0, '0);
    send_event(KIND_TIMEOUT, '0, '0, '0);
    send_event(KIND_THRESH, '0, '0, '0);
    send_event(KIND_BCAST, '0, '0, '0);
    send_event(KIND_THRESH, '0, '0, 16'sh8000);
    send_event(KIND_JOIN, '1, '1, '0);
    send_event(KIND_JOIN, '0, '0, '0);
    hold_req <= 1'b1;
    send_event(KIND_INTERVAL, '0, '0, '0);
    send_event(KIND_SENSOR, '0, '0, 16'sh7fff);
    send_event(KIND_SENSOR, '0, '0, 16'sh8000);
    send_event(KIND_TIMEOUT, '0, '0, '0);
    send_event(KIND_BCAST, tracker.own_hi, tracker.own_lo, '0);
    send_event(KIND_BCAST, '1, '1, '0);
    send_event(KIND_THRESH, '0, '0, '0);
    send_event(KIND_ALIVE, '0, '0, '0);
    send_event(KIND_TIMEOUT, '0, '0, '0);
    send_event(KIND_BCAST, '1, '1, '0);
    send_event(KIND_TIMEOUT, '0, '0, '0);
    send_event(KIND_TIMEOUT, '0, '0, '0);
    send_event(KIND_INTERVAL, '0, '0, '0);
    send_event(KIND_SENSOR, '0, '0, 16'sh1234);
    send_event(KIND_JOIN, '1, '0, '0);

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      case (p)
        0:       set_own_addr(rand64(), rand64());
        1:       set_own_addr('1, '1);
        2:       set_own_addr('0, '0);
        default: set_own_addr(rand64(), '1);
      endcase
      while (n_events < DIRECTED_N + (p + 1) * PHASE_N) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) coord_round();
        else if (pick < 80) client_round();
        else noise_round();
      end
    end
    settle();

    $display("Sent %0d events under %0d own addresses; checked %0d actions, up to %0d per event.",
             n_events, n_settings, tracker.n_checked, tracker.most_per_event);
    $display("Dropped %0d joins on a full client table; receiver held off once for %0d cycles.",
             tracker.n_dropped, LONG_HOLD);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
